// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition holds at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) cond) else $error(msg);

`endif

// ===== rtl/cdnd_pkg.sv =====
// Package of contact codes, notch decoders and level tables for the lever decoder.
package cdnd_pkg;

  localparam int SampleWidth = 17;

  localparam logic [SampleWidth-1:0] SAMPLE_RESET = '1;
  localparam logic [3:0] BRAKE_NOTCH_RESET = 4'd9;

  localparam logic [1:0] REV_FORWARD = 2'b10;
  localparam logic [1:0] REV_REVERSE = 2'b01;

  localparam logic signed [15:0] REV_LEVEL_FORWARD = 16'sh7FFF;
  localparam logic signed [15:0] REV_LEVEL_REVERSE = 16'sh8000;
  localparam logic signed [15:0] REV_LEVEL_NEUTRAL = 16'sh0000;

  localparam logic [4:0] POWER_CODE_P5 = 5'b00000;
  localparam logic [4:0] POWER_CODE_P4 = 5'b10000;
  localparam logic [4:0] POWER_CODE_P3 = 5'b11000;
  localparam logic [4:0] POWER_CODE_P2 = 5'b11100;
  localparam logic [4:0] POWER_CODE_P1 = 5'b11110;

  localparam logic [6:0] BRAKE_CODE_B0 = 7'b1111111;
  localparam logic [6:0] BRAKE_CODE_B1 = 7'b1111011;
  localparam logic [6:0] BRAKE_CODE_B2 = 7'b1100101;
  localparam logic [6:0] BRAKE_CODE_B3 = 7'b1101101;
  localparam logic [6:0] BRAKE_CODE_B4 = 7'b1001101;
  localparam logic [6:0] BRAKE_CODE_B5 = 7'b1011101;
  localparam logic [6:0] BRAKE_CODE_B6 = 7'b1010101;
  localparam logic [6:0] BRAKE_CODE_B7 = 7'b1000101;
  localparam logic [6:0] BRAKE_CODE_B8 = 7'b0000101;
  localparam logic [6:0] BRAKE_CODE_EB = 7'b1111110;

  function automatic logic [2:0] decode_power(input logic [4:0] code);
    case (code)
      POWER_CODE_P5: decode_power = 3'd5;
      POWER_CODE_P4: decode_power = 3'd4;
      POWER_CODE_P3: decode_power = 3'd3;
      POWER_CODE_P2: decode_power = 3'd2;
      POWER_CODE_P1: decode_power = 3'd1;
      default:       decode_power = 3'd0;
    endcase
  endfunction

  function automatic logic [3:0] decode_brake(input logic [6:0] code, input logic [3:0] held);
    case (code)
      BRAKE_CODE_B0: decode_brake = (held <= 4'd2) ? held : 4'd0;
      BRAKE_CODE_B1: decode_brake = 4'd1;
      BRAKE_CODE_B2: decode_brake = 4'd2;
      BRAKE_CODE_B3: decode_brake = 4'd3;
      BRAKE_CODE_B4: decode_brake = 4'd4;
      BRAKE_CODE_B5: decode_brake = 4'd5;
      BRAKE_CODE_B6: decode_brake = 4'd6;
      BRAKE_CODE_B7: decode_brake = 4'd7;
      BRAKE_CODE_B8: decode_brake = 4'd8;
      BRAKE_CODE_EB: decode_brake = 4'd9;
      default:       decode_brake = held;
    endcase
  endfunction

  // Full scale times the notch over five notches, truncated.
  function automatic logic [14:0] power_level(input logic [2:0] notch);
    case (notch)
      3'd1:    power_level = 15'd6553;
      3'd2:    power_level = 15'd13106;
      3'd3:    power_level = 15'd19660;
      3'd4:    power_level = 15'd26213;
      3'd5:    power_level = 15'd32767;
      default: power_level = 15'd0;
    endcase
  endfunction

  // Full scale times the notch over nine notches, truncated.
  function automatic logic [14:0] brake_level(input logic [3:0] notch);
    case (notch)
      4'd1:    brake_level = 15'd3640;
      4'd2:    brake_level = 15'd7281;
      4'd3:    brake_level = 15'd10922;
      4'd4:    brake_level = 15'd14563;
      4'd5:    brake_level = 15'd18203;
      4'd6:    brake_level = 15'd21844;
      4'd7:    brake_level = 15'd25485;
      4'd8:    brake_level = 15'd29126;
      4'd9:    brake_level = 15'd32767;
      default: brake_level = 15'd0;
    endcase
  endfunction

endpackage

// ===== rtl/contact_debounce_notch_decoder_top.sv =====
// Lever contact debouncer and notch decoder, top level.
// Each input word is one scan of 17 active-low lever contacts; each scan gives exactly one
// output word with the debounced reverser level, power and brake notches, their levels scaled
// to 0..32767, the debounced buttons and a flag for any change. A contact's debounced value
// follows a new sample only when two consecutive scans agree. A scan is held in an input
// register, decoded in one pass against the debounce and brake-notch state, and stored in an
// output register, so a word can be accepted every cycle unless both registers are full
// and out_ready is low; the output register lets the next scan enter while a result waits.
`include "assert_macros.svh"

module contact_debounce_notch_decoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         reverser_contacts,
  input  logic [4:0]         power_contacts,
  input  logic [6:0]         brake_contacts,
  input  logic [2:0]         button_contacts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               changed,
  output logic signed [15:0] reverser_level,
  output logic [2:0]         power_notch,
  output logic [14:0]        power_level,
  output logic [3:0]         brake_notch,
  output logic [14:0]        brake_level,
  output logic [2:0]         buttons
);

  logic                                  sample_valid;
  logic [cdnd_pkg::SampleWidth-1:0]      sample;
  logic [cdnd_pkg::SampleWidth-1:0]      prior_sample;
  logic [cdnd_pkg::SampleWidth-1:0]      debounced_contacts;
  logic [cdnd_pkg::SampleWidth-1:0]      debounced_contacts_next;
  logic [cdnd_pkg::SampleWidth-1:0]      take;
  logic [3:0]                            last_brake_notch;
  logic [3:0]                            brake_notch_next;
  logic [2:0]                            power_notch_next;
  logic signed [15:0]                    reverser_level_next;
  logic                                  advance;

  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  always_comb begin
    take = (sample ^ debounced_contacts) & ~(sample ^ prior_sample);
    debounced_contacts_next = (debounced_contacts & ~take) | (sample & take);
    case (debounced_contacts_next[1:0])
      cdnd_pkg::REV_FORWARD: reverser_level_next = cdnd_pkg::REV_LEVEL_FORWARD;
      cdnd_pkg::REV_REVERSE: reverser_level_next = cdnd_pkg::REV_LEVEL_REVERSE;
      default:               reverser_level_next = cdnd_pkg::REV_LEVEL_NEUTRAL;
    endcase
    power_notch_next = cdnd_pkg::decode_power(debounced_contacts_next[6:2]);
    brake_notch_next = cdnd_pkg::decode_brake(debounced_contacts_next[13:7], last_brake_notch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      sample <= {button_contacts, brake_contacts, power_contacts, reverser_contacts};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_sample       <= cdnd_pkg::SAMPLE_RESET;
      debounced_contacts <= cdnd_pkg::SAMPLE_RESET;
      last_brake_notch   <= cdnd_pkg::BRAKE_NOTCH_RESET;
    end else if (advance) begin
      prior_sample       <= sample;
      debounced_contacts <= debounced_contacts_next;
      last_brake_notch   <= brake_notch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      changed        <= |take;
      reverser_level <= reverser_level_next;
      power_notch    <= power_notch_next;
      power_level    <= cdnd_pkg::power_level(power_notch_next);
      brake_notch    <= brake_notch_next;
      brake_level    <= cdnd_pkg::brake_level(brake_notch_next);
      buttons        <= debounced_contacts_next[16:14];
    end
  end

  `ASSERT_CLK(a_notch_remembered, clk, rst,
    advance |=> last_brake_notch == brake_notch,
    "remembered brake notch differs from the reported one")
  `ASSERT_CLK(a_change_flag, clk, rst,
    advance && (take != '0) |=> changed && debounced_contacts != $past(debounced_contacts),
    "change flag disagrees with the debounced contacts")
  `ASSERT_CLK(a_stall_only_when_full, clk, rst,
    !in_ready |-> sample_valid && out_valid && !out_ready,
    "input stalled without a full pipeline")
  `ASSERT_CLK(a_power_level_zero, clk, rst,
    out_valid && power_notch == 3'd0 |-> power_level == 15'd0,
    "power level not zero at notch zero")

endmodule

// ===== bench/contact_debounce_notch_decoder_top_tb.sv =====
// Self-checking testbench for the lever contact debouncer and notch decoder.
`timescale 1ns / 100ps

module contact_debounce_notch_decoder_top_tb;

  localparam int RANDOM_WORDS = 1350;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic               changed_flag;
    logic signed [15:0] reverser;
    logic [2:0]         power_n;
    logic [14:0]        power_lvl;
    logic [3:0]         brake_n;
    logic [14:0]        brake_lvl;
    logic [2:0]         button_bits;
  } lever_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         reverser_contacts = '0;
  logic [4:0]         power_contacts = '0;
  logic [6:0]         brake_contacts = '0;
  logic [2:0]         button_contacts = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               changed;
  logic signed [15:0] reverser_level;
  logic [2:0]         power_notch;
  logic [14:0]        power_level;
  logic [3:0]         brake_notch;
  logic [14:0]        brake_level;
  logic [2:0]         buttons;

  logic [16:0]   prior_scan;
  logic [16:0]   settled_contacts;
  logic [3:0]    held_brake_notch;
  lever_result_t pending_results[$];

  int words_sent = 0;
  int results_seen = 0;
  int changes_seen = 0;
  int emergencies_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit steady_flow = 1'b0;

  // Scans are packed as buttons, brake, power, reverser from the top bit down.
  logic [16:0] directed_scans [27] = '{
    {3'b111, cdnd_pkg::BRAKE_CODE_B0, 5'b11111, 2'b11},
    17'h00000,
    17'h00000,
    {3'b101, cdnd_pkg::BRAKE_CODE_B1, cdnd_pkg::POWER_CODE_P1, cdnd_pkg::REV_FORWARD},
    {3'b101, cdnd_pkg::BRAKE_CODE_B1, cdnd_pkg::POWER_CODE_P1, cdnd_pkg::REV_FORWARD},
    {3'b010, cdnd_pkg::BRAKE_CODE_B2, cdnd_pkg::POWER_CODE_P2, cdnd_pkg::REV_REVERSE},
    {3'b010, cdnd_pkg::BRAKE_CODE_B2, cdnd_pkg::POWER_CODE_P2, cdnd_pkg::REV_REVERSE},
    {3'b110, cdnd_pkg::BRAKE_CODE_B3, cdnd_pkg::POWER_CODE_P3, cdnd_pkg::REV_FORWARD},
    {3'b110, cdnd_pkg::BRAKE_CODE_B3, cdnd_pkg::POWER_CODE_P3, cdnd_pkg::REV_FORWARD},
    {3'b001, cdnd_pkg::BRAKE_CODE_B4, cdnd_pkg::POWER_CODE_P4, 2'b11},
    {3'b001, cdnd_pkg::BRAKE_CODE_B4, cdnd_pkg::POWER_CODE_P4, 2'b11},
    {3'b011, cdnd_pkg::BRAKE_CODE_B5, cdnd_pkg::POWER_CODE_P5, cdnd_pkg::REV_REVERSE},
    {3'b011, cdnd_pkg::BRAKE_CODE_B5, cdnd_pkg::POWER_CODE_P5, cdnd_pkg::REV_REVERSE},
    {3'b100, cdnd_pkg::BRAKE_CODE_B6, 5'b10101, cdnd_pkg::REV_FORWARD},
    {3'b100, cdnd_pkg::BRAKE_CODE_B6, 5'b10101, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_B7, cdnd_pkg::POWER_CODE_P1, 2'b00},
    {3'b111, cdnd_pkg::BRAKE_CODE_B7, cdnd_pkg::POWER_CODE_P1, 2'b00},
    {3'b000, cdnd_pkg::BRAKE_CODE_B8, cdnd_pkg::POWER_CODE_P2, cdnd_pkg::REV_FORWARD},
    {3'b000, cdnd_pkg::BRAKE_CODE_B8, cdnd_pkg::POWER_CODE_P2, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_EB, cdnd_pkg::POWER_CODE_P3, cdnd_pkg::REV_REVERSE},
    {3'b111, cdnd_pkg::BRAKE_CODE_EB, cdnd_pkg::POWER_CODE_P3, cdnd_pkg::REV_REVERSE},
    {3'b111, 7'b0101010, cdnd_pkg::POWER_CODE_P4, cdnd_pkg::REV_FORWARD},
    {3'b111, 7'b0101010, cdnd_pkg::POWER_CODE_P4, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_B2, cdnd_pkg::POWER_CODE_P5, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_B2, cdnd_pkg::POWER_CODE_P5, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_B0, 5'b11111, cdnd_pkg::REV_FORWARD},
    {3'b111, cdnd_pkg::BRAKE_CODE_B0, 5'b11111, cdnd_pkg::REV_FORWARD}
  };

  // Results of the first three scans after reset, written out by hand.
  lever_result_t typed_results [3] = '{
    '{1'b0, 16'sd0, 3'd0, 15'd0, 4'd0, 15'd0, 3'd7},
    '{1'b0, 16'sd0, 3'd0, 15'd0, 4'd0, 15'd0, 3'd7},
    '{1'b1, 16'sd0, 3'd5, 15'd32767, 4'd0, 15'd0, 3'd0}
  };

  logic [4:0] power_codes [5] = '{
    cdnd_pkg::POWER_CODE_P1, cdnd_pkg::POWER_CODE_P2, cdnd_pkg::POWER_CODE_P3,
    cdnd_pkg::POWER_CODE_P4, cdnd_pkg::POWER_CODE_P5
  };

  logic [6:0] brake_codes [10] = '{
    cdnd_pkg::BRAKE_CODE_B0, cdnd_pkg::BRAKE_CODE_B1, cdnd_pkg::BRAKE_CODE_B2,
    cdnd_pkg::BRAKE_CODE_B3, cdnd_pkg::BRAKE_CODE_B4, cdnd_pkg::BRAKE_CODE_B5,
    cdnd_pkg::BRAKE_CODE_B6, cdnd_pkg::BRAKE_CODE_B7, cdnd_pkg::BRAKE_CODE_B8,
    cdnd_pkg::BRAKE_CODE_EB
  };

  contact_debounce_notch_decoder_top DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .reverser_contacts (reverser_contacts),
    .power_contacts    (power_contacts),
    .brake_contacts    (brake_contacts),
    .button_contacts   (button_contacts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .changed           (changed),
    .reverser_level    (reverser_level),
    .power_notch       (power_notch),
    .power_level       (power_level),
    .brake_notch       (brake_notch),
    .brake_level       (brake_level),
    .buttons           (buttons)
  );

  always #5 clk = ~clk;

  function automatic lever_result_t decode_scan(input logic [16:0] scan);
    logic [16:0]   take;
    lever_result_t res;
    int unsigned   pn;
    int unsigned   bn;
    take = (scan ^ settled_contacts) & ~(scan ^ prior_scan);
    settled_contacts = (settled_contacts & ~take) | (scan & take);
    prior_scan = scan;
    res.changed_flag = |take;
    case (settled_contacts[1:0])
      cdnd_pkg::REV_FORWARD: res.reverser = 16'sh7FFF;
      cdnd_pkg::REV_REVERSE: res.reverser = 16'sh8000;
      default:               res.reverser = 16'sh0000;
    endcase
    case (settled_contacts[6:2])
      cdnd_pkg::POWER_CODE_P5: pn = 5;
      cdnd_pkg::POWER_CODE_P4: pn = 4;
      cdnd_pkg::POWER_CODE_P3: pn = 3;
      cdnd_pkg::POWER_CODE_P2: pn = 2;
      cdnd_pkg::POWER_CODE_P1: pn = 1;
      default:                 pn = 0;
    endcase
    case (settled_contacts[13:7])
      cdnd_pkg::BRAKE_CODE_B0: bn = (held_brake_notch <= 4'd2) ? held_brake_notch : 0;
      cdnd_pkg::BRAKE_CODE_B1: bn = 1;
      cdnd_pkg::BRAKE_CODE_B2: bn = 2;
      cdnd_pkg::BRAKE_CODE_B3: bn = 3;
      cdnd_pkg::BRAKE_CODE_B4: bn = 4;
      cdnd_pkg::BRAKE_CODE_B5: bn = 5;
      cdnd_pkg::BRAKE_CODE_B6: bn = 6;
      cdnd_pkg::BRAKE_CODE_B7: bn = 7;
      cdnd_pkg::BRAKE_CODE_B8: bn = 8;
      cdnd_pkg::BRAKE_CODE_EB: bn = 9;
      default:                 bn = held_brake_notch;
    endcase
    held_brake_notch = bn[3:0];
    res.power_n = pn[2:0];
    res.power_lvl = 15'((32767 * pn) / 5);
    res.brake_n = bn[3:0];
    res.brake_lvl = 15'((32767 * bn) / 9);
    res.button_bits = settled_contacts[16:14];
    return res;
  endfunction

  function automatic string show_result(input lever_result_t r);
    return $sformatf("changed=%0b rev=%0d pn=%0d pl=%0d bn=%0d bl=%0d buttons=%b",
                     r.changed_flag, r.reverser, r.power_n, r.power_lvl,
                     r.brake_n, r.brake_lvl, r.button_bits);
  endfunction

  function automatic bit take_a_break();
    return !steady_flow && ($urandom_range(0, 99) < 12);
  endfunction

  task automatic send_scan(input logic [16:0] scan, input bit typed,
                           input lever_result_t typed_want);
    lever_result_t modelled;
    while (take_a_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {button_contacts, brake_contacts, power_contacts, reverser_contacts} <= scan;
    do @(posedge clk); while (!in_ready);
    modelled = decode_scan(scan);
    pending_results.push_back(typed ? typed_want : modelled);
    words_sent++;
  endtask

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin : check_results
    lever_result_t got;
    lever_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {changed, reverser_level, power_notch, power_level,
             brake_notch, brake_level, buttons};
      results_seen++;
      changes_seen += changed;
      if (brake_notch == 4'd9) emergencies_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result word: %s", show_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result word %0d:", results_seen);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles.", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          random_sent;
    int          reps;
    logic [16:0] scan;
    prior_scan = '1;
    settled_contacts = '1;
    held_brake_notch = 4'd9;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 27; i++) begin
      send_scan(directed_scans[i], i < 3, (i < 3) ? typed_results[i] : '0);
    end

    // Mostly steady lever positions held for a few scans, with chatter and noise mixed in.
    while (random_sent < RANDOM_WORDS) begin
      scan[1:0] = 2'($urandom_range(0, 3));
      scan[6:2] = ($urandom_range(0, 99) < 80) ? power_codes[$urandom_range(0, 4)]
                                               : 5'($urandom_range(0, 31));
      scan[13:7] = ($urandom_range(0, 99) < 80) ? brake_codes[$urandom_range(0, 9)]
                                                : 7'($urandom_range(0, 127));
      scan[16:14] = 3'($urandom_range(0, 7));
      reps = $urandom_range(1, 4);
      for (int r = 0; r < reps; r++) begin
        steady_flow = (random_sent >= 500) && (random_sent < 800);
        if ($urandom_range(0, 99) < 15) begin
          send_scan(scan ^ (17'd1 << $urandom_range(0, 16)), 1'b0, '0);
          random_sent++;
        end
        send_scan(scan, 1'b0, '0);
        random_sent++;
      end
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d scan words and checked %0d result words.", words_sent, results_seen);
    $display("%0d results carried a debounced change, %0d showed the emergency notch.",
             changes_seen, emergencies_seen);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d result words failed.", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
